@@ src/bsc_pkg.sv @@
package bsc_pkg;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned RawW      = 19;
  localparam int unsigned ValW      = 32;

  localparam logic [CfgIdxW-1:0] REG_OFFSET = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SCALE  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TEMP   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PCURVE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TCURVE = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OSS    = 3'd5;

  localparam logic [31:0] C_4000  = 32'd4000;
  localparam logic [31:0] C_3038  = 32'd3038;
  localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
  localparam logic [31:0] C_3791  = 32'd3791;
  localparam logic [31:0] C_50000 = 32'd50000;
  localparam logic [31:0] C_MSB   = 32'h8000_0000;
  localparam logic [31:0] C_32768 = 32'd32768;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    return 32'($signed(v) >>> s);
  endfunction
endpackage

@@ src/bsc_if.sv @@
interface bsc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [18:0] raw_sample;
  modport source (output valid, func, raw_sample, input ready);
  modport sink   (input valid, func, raw_sample, output ready);
endinterface

interface bsc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] value;
  logic        div_error;
  modport source (output valid, result_kind, value, div_error, input ready);
  modport sink   (input valid, result_kind, value, div_error, output ready);
endinterface

interface bsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/bsc_div.sv @@
// unsigned 32/32 restoring divider, one quotient bit a cycle
module bsc_div
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[31]} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

@@ src/baro_sensor_compensation.sv @@
// Baro sensor compensation: one item at a time.
// A temperature or a pressure item runs through the serial divider, which dominates; on a
// zero divisor the divide is skipped and div_error is set. The multiplies go through one
// shared 32x32 multiplier, one product a cycle. The next input is taken in the cycle after
// the result leaves.
// Reset (async, active low) clears calibration registers, the stored term and control state.
module baro_sensor_compensation
  import bsc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  bsc_in_if.sink    in_if,
  bsc_out_if.source out_if,
  bsc_cfg_if.sink   cfg_if
);
  // sequencer steps
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_T1   = 5'd1;  // x1 = (raw-ac6)*ac5 >>15
  localparam logic [4:0] S_T2   = 5'd2;  // start divide
  localparam logic [4:0] S_TW   = 5'd3;
  localparam logic [4:0] S_P1   = 5'd4;  // b6*b6
  localparam logic [4:0] S_P2   = 5'd5;  // b2*sq
  localparam logic [4:0] S_P3   = 5'd6;  // ac2*b6
  localparam logic [4:0] S_P4   = 5'd7;  // ac3*b6
  localparam logic [4:0] S_P5   = 5'd8;  // b1*sq
  localparam logic [4:0] S_P6   = 5'd9;  // ac4*(x3+32768)
  localparam logic [4:0] S_P7   = 5'd10; // b7
  localparam logic [4:0] S_P8   = 5'd11; // start divide
  localparam logic [4:0] S_PW   = 5'd12;
  localparam logic [4:0] S_P9   = 5'd13; // (p>>8)^2
  localparam logic [4:0] S_P10  = 5'd14; // *3038
  localparam logic [4:0] S_P11  = 5'd15; // -7357*p
  localparam logic [4:0] S_P12  = 5'd16; // final sum
  localparam logic [4:0] S_OUT  = 5'd17;

  logic [47:0] ofs_q;
  logic [15:0] scl_q;
  logic [31:0] tc_q, pc_q, tcv_q;
  logic [1:0]  oss_q;
  logic [31:0] b5_q;

  logic [4:0]  st_q;
  logic        kind_q;
  logic [31:0] raw_q;
  logic [31:0] a_q, b_q, c_q, e_q;   // working registers
  logic [31:0] val_q;
  logic        err_q;
  logic        neg_q;

  // shared multiplier operands
  logic [31:0] ma, mb, prod;
  assign prod = ma * mb;

  logic        dv_start, dv_done;
  logic [31:0] dv_num, dv_den, dv_quo;

  bsc_div u_div (
    .clk_i, .rst_ni,
    .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  wire [31:0] ac1 = sx16(ofs_q[47:32]);
  wire [31:0] ac2 = sx16(ofs_q[31:16]);
  wire [31:0] ac3 = sx16(ofs_q[15:0]);
  wire [31:0] ac4 = {16'd0, scl_q};
  wire [31:0] ac5 = {16'd0, tc_q[31:16]};
  wire [31:0] ac6 = {16'd0, tc_q[15:0]};
  wire [31:0] b1  = sx16(pc_q[31:16]);
  wire [31:0] b2  = sx16(pc_q[15:0]);
  wire [31:0] mc  = sx16(tcv_q[31:16]);
  wire [31:0] md  = sx16(tcv_q[15:0]);
  wire [31:0] b6  = b5_q - C_4000;

  // temperature divide operands (a_q = x1)
  wire [31:0] tn = mc << 11;
  wire [31:0] td = a_q + md;
  // pressure: b_q = b7, c_q = b4
  wire        pbig = b_q[31];

  logic [31:0] b3;
  always_comb begin
    b3 = asr(((ac1 << 2) + e_q) << oss_q, 5'd0);
    b3 = asr(b3 + 32'd2, 5'd2);
  end

  always_comb begin
    ma = a_q; mb = b_q;
    case (st_q)
      S_T1:  begin ma = raw_q - ac6; mb = ac5; end
      S_P1:  begin ma = b6;  mb = b6; end
      S_P2:  begin ma = b2;  mb = a_q; end
      S_P3:  begin ma = ac2; mb = b6; end
      S_P4:  begin ma = ac3; mb = b6; end
      S_P5:  begin ma = b1;  mb = a_q; end
      S_P6:  begin ma = ac4; mb = c_q + C_32768; end
      S_P7:  begin ma = raw_q - b3; mb = C_50000 >> oss_q; end
      S_P9:  begin ma = asr(val_q, 5'd8); mb = asr(val_q, 5'd8); end
      S_P10: begin ma = a_q; mb = C_3038; end
      S_P11: begin ma = C_M7357; mb = val_q; end
      default: begin ma = a_q; mb = b_q; end
    endcase
  end

  always_comb begin
    dv_start = 1'b0;
    dv_num   = tn;
    dv_den   = td;
    if (st_q == S_T2) begin
      dv_start = (td != 0);
      dv_num   = tn[31] ? 32'd0 - tn : tn;
      dv_den   = td[31] ? 32'd0 - td : td;
    end else if (st_q == S_P8) begin
      dv_start = (c_q != 0);
      dv_num   = pbig ? b_q : (b_q << 1);
      dv_den   = c_q;
    end
  end

  assign in_if.ready  = (st_q == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid       = (st_q == S_OUT);
  assign out_if.result_kind = kind_q;
  assign out_if.value       = val_q;
  assign out_if.div_error   = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      ofs_q <= '0; scl_q <= '0; tc_q <= '0; pc_q <= '0; tcv_q <= '0; oss_q <= '0;
      b5_q  <= '0;
    end else begin
      if (cfg_if.valid) begin
        case (cfg_if.index)
          REG_OFFSET: ofs_q <= cfg_if.data;
          REG_SCALE:  scl_q <= cfg_if.data[15:0];
          REG_TEMP:   tc_q  <= cfg_if.data[31:0];
          REG_PCURVE: pc_q  <= cfg_if.data[31:0];
          REG_TCURVE: tcv_q <= cfg_if.data[31:0];
          REG_OSS:    oss_q <= cfg_if.data[1:0];
          default: ;
        endcase
      end
      case (st_q)
        S_IDLE: if (in_if.valid) st_q <= in_if.func ? S_P1 : S_T1;
        S_T1:   st_q <= S_T2;
        S_T2:   st_q <= (td == 0) ? S_OUT : S_TW;
        S_TW: if (dv_done) begin
          b5_q  <= a_q + (neg_q ? 32'd0 - dv_quo : dv_quo);
          st_q  <= S_OUT;
        end
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7: st_q <= st_q + 5'd1;
        S_P8:   st_q <= (c_q == 0) ? S_OUT : S_PW;
        S_PW:   if (dv_done) st_q <= S_P9;
        S_P9, S_P10, S_P11: st_q <= st_q + 5'd1;
        S_P12:  st_q <= S_OUT;
        S_OUT:  if (out_if.ready) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        kind_q <= in_if.func;
        raw_q  <= {13'd0, in_if.raw_sample};
        err_q  <= 1'b0;
        val_q  <= '0;
      end
      S_T1: a_q <= asr(prod, 5'd15);
      S_T2: begin
        neg_q <= tn[31] ^ td[31];
        if (td == 0) err_q <= 1'b1;
      end
      S_TW: if (dv_done) val_q <= asr(a_q + (neg_q ? 32'd0 - dv_quo : dv_quo) + 32'd8,
                                      5'd4);
      S_P1: a_q <= asr(prod, 5'd12);             // sq
      S_P2: e_q <= asr(prod, 5'd11);             // x1
      S_P3: e_q <= e_q + asr(prod, 5'd11);       // x3
      S_P4: c_q <= asr(prod, 5'd13);             // x1'
      S_P5: c_q <= asr(c_q + asr(prod, 5'd16) + 32'd2, 5'd2); // x3'
      S_P6: c_q <= prod >> 15;                   // b4
      S_P7: b_q <= prod;                         // b7
      S_P8: if (c_q == 0) err_q <= 1'b1;
      S_PW: if (dv_done) val_q <= pbig ? (dv_quo << 1) : dv_quo;
      S_P9:  a_q <= prod;
      S_P10: a_q <= asr(prod, 5'd16);
      S_P11: b_q <= asr(prod, 5'd16);
      S_P12: val_q <= val_q + asr(a_q + b_q + C_3791, 5'd4);
      default: ;
    endcase
  end
endmodule
